/* sv/bsl_pkg.sv */
package bsl_pkg;

  localparam int DefCapacity = 8;

  // operation codes
  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_PREPEND   = 3'd1;
  localparam logic [2:0] OP_INSERT_AT = 3'd2;
  localparam logic [2:0] OP_DEL_LAST  = 3'd3;
  localparam logic [2:0] OP_DEL_FIRST = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;
  localparam logic [2:0] OP_READ      = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] item_value;
    logic [3:0]         position;
  } list_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         count_after;
    logic signed [31:0] read_value;
  } list_res_t;

endpackage

/* sv/bounded_shift_list.sv */
// Ordered list of up to CAPACITY signed 32-bit entries with a fill count.
// Command channel: drive cmd and pulse start; the item is taken at a rising
// edge where start is high and busy is low. busy stays low, so one item can
// be issued every cycle.
// Each item is latched into an input register, then one pass of logic
// shifts or loads every slot in parallel and fills the result register.
// The result appears on result with done high for exactly one cycle, after
// the item has passed the input and result registers. Items complete in issue
// order and the rate is one item per cycle, set by the single slot-update pass.
// Every item returns a status (ok, full, empty, bad position), the count
// after the operation, and the read value (zero unless a successful read).
// On any error the list is left unchanged.
// Reset (rst, synchronous, active high) empties the list and drops any
// item in flight; slot contents are not cleared and are never read before
// being written. There is no back-pressure: the receiver must take each
// result in the cycle it is shown.
module bounded_shift_list #(
  parameter int CAPACITY = bsl_pkg::DefCapacity
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bsl_pkg::list_cmd_t cmd,
  output logic               done,
  output bsl_pkg::list_res_t result
);
  import bsl_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic               cmd_valid;
  list_cmd_t          cmd_q;
  logic signed [31:0] slots [CAPACITY];
  logic signed [31:0] slots_next [CAPACITY];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  list_res_t          result_next;

  logic [CMPW-1:0]    cnt_x;
  logic [CMPW-1:0]    pos_x;
  logic [CMPW-1:0]    at_x;
  logic               full;
  logic               empty;
  logic               do_ins;
  logic               do_del;
  logic signed [31:0] rd;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    cnt_x       = CMPW'(count);
    pos_x       = CMPW'(cmd_q.position);
    full        = (count == CW'(CAPACITY));
    empty       = (count == '0);
    at_x        = '0;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    count_next  = count;
    rd          = '0;
    result_next = '0;
    result_next.status = ST_OK;

    for (int k = 0; k < CAPACITY; k++) begin
      if (pos_x == CMPW'(k)) begin
        rd = slots[k];
      end
    end

    unique case (cmd_q.func)
      OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
        if (cmd_q.func == OP_APPEND) begin
          at_x = cnt_x;
        end else if (cmd_q.func == OP_INSERT_AT) begin
          at_x = pos_x;
        end
        if (full) begin
          result_next.status = ST_FULL;
        end else if (cmd_q.func == OP_INSERT_AT && pos_x > cnt_x) begin
          result_next.status = ST_BADPOS;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_DEL_LAST: begin
        if (empty) begin
          result_next.status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_DEL_FIRST, OP_DEL_AT: begin
        if (cmd_q.func == OP_DEL_AT) begin
          at_x = pos_x;
        end
        if (empty) begin
          result_next.status = ST_EMPTY;
        end else if (cmd_q.func == OP_DEL_AT && pos_x >= cnt_x) begin
          result_next.status = ST_BADPOS;
        end else begin
          do_del     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        if (pos_x >= cnt_x) begin
          result_next.status = ST_BADPOS;
        end else begin
          result_next.read_value = rd;
        end
      end
    endcase

    // each slot holds, takes a neighbor, or takes the new value
    for (int k = 0; k < CAPACITY; k++) begin
      slots_next[k] = slots[k];
      if (do_ins) begin
        if (CMPW'(k) == at_x) begin
          slots_next[k] = cmd_q.item_value;
        end else if (k > 0 && CMPW'(k) > at_x) begin
          slots_next[k] = slots[(k > 0) ? k - 1 : 0];
        end
      end else if (do_del) begin
        if (k < CAPACITY - 1 && CMPW'(k) >= at_x) begin
          slots_next[k] = slots[(k < CAPACITY - 1) ? k + 1 : k];
        end
      end
    end

    result_next.count_after = 4'(CMPW'(count_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd_valid;
      if (cmd_valid) begin
        count <= count_next;
      end
    end
    if (cmd_valid) begin
      slots  <= slots_next;
      result <= result_next;
    end
  end

  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |=> done)
    else $error("result strobe missing after item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> count == $past(count))
    else $error("list changed on error");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.read_value == '0)
    else $error("read value set on error");

  a_count_reported: assert property (@(posedge clk) disable iff (rst)
    done |-> result.count_after == 4'(CMPW'(count)))
    else $error("reported count differs from list count");

endmodule
